// ===== design/spiral_matrix_reorder_core_assert.svh =====
// Assertion macros for the spiral matrix reorder core.
// Included by the top level; relies on nothing else.
`ifndef SPIRAL_MATRIX_REORDER_CORE_ASSERT_SVH
`define SPIRAL_MATRIX_REORDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SMR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/smr_pkg.sv =====
// Shared types and constants for the spiral matrix reorder core.
// No dependencies.
`timescale 1ns / 1ps

package smr_pkg;

  localparam int DATA_W = 32;
  localparam int SIZE_W = 4;          // width of the rows / cols registers
  localparam int IDX_W  = 3;          // width of a row or column index
  localparam int TOT_W  = 2 * SIZE_W; // width of rows * cols
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

  typedef enum logic [2:0] {
    S_FILL,
    S_RIGHT,
    S_DOWN,
    S_LEFT,
    S_UP
  } smr_state_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } smr_cmd_t;

  typedef struct packed {
    logic [SIZE_W-1:0] nr;
    logic [SIZE_W-1:0] nc;
    logic [TOT_W-1:0]  total;
    logic              complete;
    logic              rd_free;
  } smr_sts_t;

endpackage

// ===== design/smr_datapath.sv =====
// Datapath: size registers, fill counter, element store and read/output stages.
// Depends on smr_pkg.
`timescale 1ns / 1ps

module smr_datapath #(
  parameter int ROWS_MAX = 8,
  parameter int COLS_MAX = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [smr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [smr_pkg::SIZE_W-1:0]            cfg_data,
  input  logic signed [smr_pkg::DATA_W-1:0]     in_element,
  input  smr_pkg::smr_cmd_t                     cmd,
  output smr_pkg::smr_sts_t                     sts,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [smr_pkg::DATA_W-1:0]     out_value,
  output logic [smr_pkg::IDX_W-1:0]             out_row_index,
  output logic [smr_pkg::IDX_W-1:0]             out_col_index,
  output logic                                  out_last
);
  import smr_pkg::*;

  localparam int DEPTH  = ROWS_MAX * COLS_MAX;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [SIZE_W-1:0] rows_r, rows_nxt, cols_r, cols_nxt;
  logic [SIZE_W-1:0] nr, nc;
  logic [TOT_W-1:0]  total, fill_inc, rd_addr_full;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              complete;

  logic [DATA_W-1:0] mem [DEPTH];

  logic              rd_valid_r, rd_valid_nxt;
  logic [DATA_W-1:0] rd_data_r;
  logic [IDX_W-1:0]  rd_row_r, rd_col_r;
  logic              rd_last_r;
  logic              out_valid_r, out_valid_nxt, out_load;
  logic signed [DATA_W-1:0] out_value_r;
  logic [IDX_W-1:0]  out_row_r, out_col_r;
  logic              out_last_r;

  // Size registers, decoded by index
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS: rows_nxt = cfg_data;
        CFG_COLS: cols_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp out-of-range sizes
  assign nr = (rows_r == '0) ? SIZE_W'(1) :
              (rows_r > SIZE_W'(ROWS_MAX)) ? SIZE_W'(ROWS_MAX) : rows_r;
  assign nc = (cols_r == '0) ? SIZE_W'(1) :
              (cols_r > SIZE_W'(COLS_MAX)) ? SIZE_W'(COLS_MAX) : cols_r;
  assign total = TOT_W'(nr) * TOT_W'(nc);

  assign fill_inc = TOT_W'(fill_r) + TOT_W'(1);
  assign complete = cmd.wr_en && (fill_inc >= total);
  assign fill_nxt = complete ? '0 : (cmd.wr_en ? CNT_W'(fill_inc) : fill_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= SIZE_W'(1);
      cols_r <= SIZE_W'(1);
      fill_r <= '0;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Element store
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[fill_r[ADDR_W-1:0]] <= in_element;
    end
  end

  assign rd_addr_full = TOT_W'(cmd.row) * TOT_W'(nc) + TOT_W'(cmd.col);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr_full[ADDR_W-1:0]];
      rd_row_r  <= cmd.row;
      rd_col_r  <= cmd.col;
      rd_last_r <= cmd.last;
    end
  end

  // Read stage feeds the output register; stall the read stage while the output is held
  assign out_load      = rd_valid_r && (!out_valid_r || out_ready);
  assign rd_valid_nxt  = cmd.rd_en || (rd_valid_r && !out_load);
  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= signed'(rd_data_r);
      out_row_r   <= rd_row_r;
      out_col_r   <= rd_col_r;
      out_last_r  <= rd_last_r;
    end
  end

  assign sts.nr       = nr;
  assign sts.nc       = nc;
  assign sts.total    = total;
  assign sts.complete = complete;
  assign sts.rd_free  = !rd_valid_r || out_load;

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_row_index = out_row_r;
  assign out_col_index = out_col_r;
  assign out_last      = out_last_r;

endmodule

// ===== design/smr_ctrl.sv =====
// Controller: fill/emit state machine and spiral cursor with shrinking bounds.
// Depends on smr_pkg.
`timescale 1ns / 1ps

module smr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  smr_pkg::smr_sts_t sts,
  output smr_pkg::smr_cmd_t cmd
);
  import smr_pkg::*;

  smr_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [IDX_W-1:0] top_r, top_nxt, bot_r, bot_nxt;
  logic [IDX_W-1:0] lft_r, lft_nxt, rgt_r, rgt_nxt;
  logic [TOT_W-1:0] cnt_r, cnt_nxt;
  logic             issue, last_hit;

  assign issue    = (state_r != S_FILL) && sts.rd_free;
  assign last_hit = (cnt_r == sts.total - TOT_W'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_FILL:  if (sts.complete) state_nxt = S_RIGHT;
      S_RIGHT: if (issue) begin
        if (last_hit) state_nxt = S_FILL;
        else if (col_r == rgt_r) state_nxt = S_DOWN;
      end
      S_DOWN: if (issue) begin
        if (last_hit) state_nxt = S_FILL;
        else if (row_r == bot_r) state_nxt = S_LEFT;
      end
      S_LEFT: if (issue) begin
        if (last_hit) state_nxt = S_FILL;
        else if (col_r == lft_r) state_nxt = S_UP;
      end
      S_UP: if (issue) begin
        if (last_hit) state_nxt = S_FILL;
        else if (row_r == top_r) state_nxt = S_RIGHT;
      end
      default: state_nxt = S_FILL;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = (state_r == S_FILL);
    cmd.wr_en = in_valid && (state_r == S_FILL);
    cmd.rd_en = issue;
    cmd.row   = row_r;
    cmd.col   = col_r;
    cmd.last  = last_hit;
  end

  // Cursor: step along the current side, turn and shrink a bound at its end
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    top_nxt = top_r;
    bot_nxt = bot_r;
    lft_nxt = lft_r;
    rgt_nxt = rgt_r;
    cnt_nxt = cnt_r;
    if ((state_r == S_FILL) && sts.complete) begin
      row_nxt = '0;
      col_nxt = '0;
      top_nxt = '0;
      lft_nxt = '0;
      bot_nxt = IDX_W'(sts.nr - SIZE_W'(1));
      rgt_nxt = IDX_W'(sts.nc - SIZE_W'(1));
      cnt_nxt = '0;
    end else if (issue) begin
      cnt_nxt = cnt_r + TOT_W'(1);
      case (state_r)
        S_RIGHT: begin
          if (col_r == rgt_r) begin
            top_nxt = top_r + IDX_W'(1);
            row_nxt = row_r + IDX_W'(1);
          end else begin
            col_nxt = col_r + IDX_W'(1);
          end
        end
        S_DOWN: begin
          if (row_r == bot_r) begin
            rgt_nxt = rgt_r - IDX_W'(1);
            col_nxt = col_r - IDX_W'(1);
          end else begin
            row_nxt = row_r + IDX_W'(1);
          end
        end
        S_LEFT: begin
          if (col_r == lft_r) begin
            bot_nxt = bot_r - IDX_W'(1);
            row_nxt = row_r - IDX_W'(1);
          end else begin
            col_nxt = col_r - IDX_W'(1);
          end
        end
        S_UP: begin
          if (row_r == top_r) begin
            lft_nxt = lft_r + IDX_W'(1);
            col_nxt = col_r + IDX_W'(1);
          end else begin
            row_nxt = row_r - IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    col_r <= col_nxt;
    top_r <= top_nxt;
    bot_r <= bot_nxt;
    lft_r <= lft_nxt;
    rgt_r <= rgt_nxt;
  end

endmodule

// ===== design/spiral_matrix_reorder_core.sv =====
// Spiral matrix reorder core: one element per cycle while filling, one result per cycle
// while emitting (out_ready high). The first result passes the state register, the read
// register and the output register after the completing transfer. Fill and emit do not
// overlap: the input stays closed until the last read of a run has been issued.
// Synchronous active-low reset clears the fill count and sets rows and cols to 1;
// the element store is not cleared.
`timescale 1ns / 1ps
`include "spiral_matrix_reorder_core_assert.svh"

module spiral_matrix_reorder_core #(
  parameter int ROWS_MAX = 8,
  parameter int COLS_MAX = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [smr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smr_pkg::SIZE_W-1:0]        cfg_data,
  // element input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [smr_pkg::DATA_W-1:0] in_element,
  // spiral result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [smr_pkg::DATA_W-1:0] out_value,
  output logic [smr_pkg::IDX_W-1:0]         out_row_index,
  output logic [smr_pkg::IDX_W-1:0]         out_col_index,
  output logic                              out_last
);
  import smr_pkg::*;

  // Commands flow from the controller to the datapath, status flows back.
  smr_cmd_t cmd;
  smr_sts_t sts;

  // The controller takes element transfers while filling. The transfer that
  // completes rows * cols elements starts a spiral run: it walks right, down,
  // left and up, shrinking one bound at each turn, and issues one store read
  // per cycle whenever the read stage has room. The run ends on a count of
  // rows * cols reads, which also marks the last result.
  smr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the size registers, the fill count, the store, a
  // registered read stage and the output register. The read stage takes one
  // more read while a result waits; a stalled result then holds both.
  smr_datapath #(
    .ROWS_MAX (ROWS_MAX),
    .COLS_MAX (COLS_MAX)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_element    (in_element),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_row_index (out_row_index),
    .out_col_index (out_col_index),
    .out_last      (out_last)
  );

  // Never issue a read into an occupied read stage
  `SMR_ASSERT_NOW(a_rd_slot_free, clk, rst_n, cmd.rd_en, sts.rd_free, "read stage overrun")
  // Fill and emit never overlap
  `SMR_ASSERT_NOW(a_no_fill_during_run, clk, rst_n, cmd.wr_en, !cmd.rd_en, "write during run")
  // A completing transfer starts a run and closes the input
  `SMR_ASSERT_NEXT(a_run_starts, clk, rst_n, sts.complete, !in_ready, "run did not start")
  // The last read of a run reopens the input
  `SMR_ASSERT_NEXT(a_run_ends, clk, rst_n, cmd.rd_en && cmd.last, in_ready, "input not reopened")

endmodule
